// ===== rtl/pfdts_pkg.sv =====
// ----------------------------------------------------------------------------
// pfdts_pkg
// shared types and constants of the departure time shaper
// ----------------------------------------------------------------------------
`default_nettype none
package pfdts_pkg;

   localparam int TIME_W     = 64;
   localparam int LEN_W      = 16;
   localparam int FLOW_IDX_W = 10;
   localparam int RATE_W     = 40;
   localparam int LIMIT_W    = 48;
   localparam int CSR_DATA_W = 48;
   localparam int CSR_IDX_W  = 3;
   localparam int NS_W       = 30;
   localparam int PROD_W     = 46;
   localparam int DIV_STEPS  = PROD_W;
   localparam int DIV_CNT_W  = 6;

   localparam logic [NS_W-1:0]   NS_PER_SECOND       = NS_W'(1000000000);
   localparam logic [TIME_W-1:0] DOWNLOAD_BACKLOG_NS = 64'd2000000000;
   localparam logic [TIME_W-1:0] UPLOAD_BACKLOG_NS   = 64'd200000000;

   typedef enum logic [1:0] {
      MODE_OFF     = 2'd0,
      MODE_FLOW    = 2'd1,
      MODE_DYNAMIC = 2'd2,
      MODE_SHARED  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE           = 3'd0,
      CSR_DOWNLOAD_RATE  = 3'd1,
      CSR_UPLOAD_RATE    = 3'd2,
      CSR_PENALTY_RATE   = 3'd3,
      CSR_BURST_LIMIT    = 3'd4,
      CSR_WINDOW_LENGTH  = 3'd5,
      CSR_PENALTY_LENGTH = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [TIME_W-1:0] window_count;
      logic [TIME_W-1:0] window_start;
      logic [TIME_W-1:0] penalty_end;
      logic [TIME_W-1:0] depart_time;
      logic              penalty_flag;
   } record_type;

   localparam int RECORD_W = $bits(record_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_CHECK,
      ST_DIV,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic accept;
      logic clear;
      logic read;
      logic eval;
      logic check;
      logic div_step;
      logic write;
      logic load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic mode_off;
      logic drop;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== rtl/pfdts_if.sv =====
// ----------------------------------------------------------------------------
// pfdts request and response interfaces
// valid/ready channels carrying packet and verdict transactions
// ----------------------------------------------------------------------------
`default_nettype none
interface pfdts_req_if import pfdts_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic                  direction;
   logic [FLOW_IDX_W-1:0] flow_index;
   logic [LEN_W-1:0]      packet_length;
   logic [TIME_W-1:0]     now;

   modport source (output valid, direction, flow_index, packet_length, now, input ready);
   modport sink   (input valid, direction, flow_index, packet_length, now, output ready);
endinterface

interface pfdts_rsp_if import pfdts_pkg::*;;
   logic              valid;
   logic              ready;
   logic              drop;
   logic              timed;
   logic [TIME_W-1:0] departure_time;
   logic              penalized;

   modport source (output valid, drop, timed, departure_time, penalized, input ready);
   modport sink   (input valid, drop, timed, departure_time, penalized, output ready);
endinterface
`default_nettype wire

// ===== rtl/pfdts_ram.sv =====
// ----------------------------------------------------------------------------
// pfdts_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module pfdts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     write_enable,
   input  wire logic [$clog2(DEPTH)-1:0] write_addr,
   input  wire logic [WIDTH-1:0]         write_data,
   input  wire logic                     read_enable,
   input  wire logic [$clog2(DEPTH)-1:0] read_addr,
   output logic      [WIDTH-1:0]         read_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      if (read_enable) begin
         read_data <= mem[read_addr];
      end
   end
endmodule
`default_nettype wire

// ===== rtl/pfdts_ctrl.sv =====
// ----------------------------------------------------------------------------
// pfdts_ctrl
// sequencer: clearing pass, per packet steps, divider count, output handshake
// ----------------------------------------------------------------------------
`default_nettype none
module pfdts_ctrl import pfdts_pkg::*; #(
   parameter int FLOWS = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   input  wire dp_status_type               status,
   output ctrl_cmd_type                     cmd,
   output logic [$clog2(2*FLOWS)-1:0]       clr_addr
);
   localparam int AW = $clog2(2 * FLOWS);
   localparam logic [AW-1:0] LAST_ENTRY = AW'(2 * FLOWS - 1);

   state_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign clr_addr  = clr_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == LAST_ENTRY) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid) state_in = status.mode_off ? ST_DONE : ST_READ;
         end
         ST_READ:  state_in = ST_EVAL;
         ST_EVAL:  state_in = ST_CHECK;
         ST_CHECK: state_in = status.drop ? ST_WRITE : ST_DIV;
         ST_DIV:   if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = ST_WRITE;
         ST_WRITE: state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      clr_in    = clr_ff;
      cnt_in    = cnt_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            clr_in    = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_READ:  cmd.read  = 1'b1;
         ST_EVAL:  cmd.eval  = 1'b1;
         ST_CHECK: begin
            cmd.check = 1'b1;
            cnt_in    = '0;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + DIV_CNT_W'(1);
         end
         ST_WRITE: cmd.write    = 1'b1;
         ST_DONE:  cmd.load_out = out_free;
         default: ;
      endcase
   end

   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/pfdts_dp.sv =====
// ----------------------------------------------------------------------------
// pfdts_dp
// datapath: config registers, flow record memory, burst logic, divider
// ----------------------------------------------------------------------------
`default_nettype none
module pfdts_dp import pfdts_pkg::*; #(
   parameter int FLOWS = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire ctrl_cmd_type                cmd,
   output dp_status_type                    status,
   input  wire logic [$clog2(2*FLOWS)-1:0]  clr_addr,
   input  wire logic                        in_direction,
   input  wire logic [FLOW_IDX_W-1:0]       in_flow_index,
   input  wire logic [LEN_W-1:0]            in_packet_length,
   input  wire logic [TIME_W-1:0]           in_now,
   input  wire logic                        csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]       csr_write_data,
   output logic                             out_drop,
   output logic                             out_timed,
   output logic [TIME_W-1:0]                out_departure_time,
   output logic                             out_penalized
);
   localparam int AW = $clog2(2 * FLOWS);
   localparam int RW = 17;
   localparam logic [AW-1:0] FLOWS_A = AW'(FLOWS);
   localparam logic [RW-1:0] FLOWS_R = RW'(FLOWS);

   function automatic logic [AW-1:0] reduce_flow(input logic [FLOW_IDX_W-1:0] v);
      logic [RW-1:0] r;
      r = '0;
      for (int i = FLOW_IDX_W - 1; i >= 0; i--) begin
         r = {r[RW-2:0], v[i]};
         if (r >= FLOWS_R) r = r - FLOWS_R;
      end
      return AW'(r);
   endfunction

   // configuration
   mode_type          mode_ff;
   logic [RATE_W-1:0] down_rate_ff, up_rate_ff, pen_rate_ff, window_ff, pen_len_ff;
   logic [LIMIT_W-1:0] burst_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_OFF;
         down_rate_ff <= '0;
         up_rate_ff   <= '0;
         pen_rate_ff  <= '0;
         burst_ff     <= '0;
         window_ff    <= '0;
         pen_len_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MODE:           mode_ff      <= mode_type'(csr_write_data[1:0]);
            CSR_DOWNLOAD_RATE:  down_rate_ff <= csr_write_data[RATE_W-1:0];
            CSR_UPLOAD_RATE:    up_rate_ff   <= csr_write_data[RATE_W-1:0];
            CSR_PENALTY_RATE:   pen_rate_ff  <= csr_write_data[RATE_W-1:0];
            CSR_BURST_LIMIT:    burst_ff     <= csr_write_data[LIMIT_W-1:0];
            CSR_WINDOW_LENGTH:  window_ff    <= csr_write_data[RATE_W-1:0];
            CSR_PENALTY_LENGTH: pen_len_ff   <= csr_write_data[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // packet registers
   logic              dir_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [TIME_W-1:0] now_ff;
   logic [AW-1:0]     addr_ff, addr_in, flow_a;
   logic [PROD_W-1:0] prod_ff;

   assign flow_a  = (mode_ff == MODE_SHARED) ? '0 : reduce_flow(in_flow_index);
   assign addr_in = in_direction ? FLOWS_A + flow_a : flow_a;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         dir_ff  <= in_direction;
         len_ff  <= in_packet_length;
         now_ff  <= in_now;
         addr_ff <= addr_in;
         prod_ff <= PROD_W'(in_packet_length) * PROD_W'(NS_PER_SECOND);
      end
   end

   // record memory
   record_type rd_rec, wr_rec;

   pfdts_ram #(.WIDTH(RECORD_W), .DEPTH(2 * FLOWS)) u_ram (
      .clock        (clock),
      .write_enable (cmd.clear || cmd.write),
      .write_addr   (cmd.clear ? clr_addr : addr_ff),
      .write_data   (cmd.clear ? '0 : wr_rec),
      .read_enable  (cmd.read),
      .read_addr    (addr_ff),
      .read_data    (rd_rec)
   );

   // burst window and penalty update
   logic [TIME_W-1:0] wc_ff, ws_ff, pe_ff, nd_ff, nd_in;
   logic              flag_ff;
   logic [TIME_W-1:0] wc, ws, pe;
   logic              flag;

   always_comb begin
      wc   = rd_rec.window_count;
      ws   = rd_rec.window_start;
      pe   = rd_rec.penalty_end;
      flag = rd_rec.penalty_flag;
      if (mode_ff == MODE_DYNAMIC) begin
         if (flag && now_ff >= pe) begin
            flag = 1'b0;
            pe   = '0;
            ws   = now_ff;
            wc   = '0;
         end
         if (!flag) begin
            if (ws == '0 || (now_ff - ws) >= TIME_W'(window_ff)) begin
               ws = now_ff;
               wc = '0;
            end
            wc = wc + TIME_W'(len_ff);
            if (wc > TIME_W'(burst_ff)) begin
               flag = 1'b1;
               pe   = now_ff + TIME_W'(pen_len_ff);
            end
         end
      end
   end

   // rate selection and backlog check
   logic [RATE_W-1:0] rate;
   logic [TIME_W-1:0] dep, limit;
   logic              drop_now;

   always_comb begin
      if (mode_ff == MODE_DYNAMIC && flag_ff) rate = pen_rate_ff;
      else if (dir_ff)                        rate = up_rate_ff;
      else                                    rate = down_rate_ff;
      dep      = (nd_ff < now_ff) ? now_ff : nd_ff;
      limit    = dir_ff ? UPLOAD_BACKLOG_NS : DOWNLOAD_BACKLOG_NS;
      drop_now = (rate == '0) || ((dep - now_ff) > limit);
   end

   assign status.mode_off = (mode_ff == MODE_OFF);
   assign status.drop     = drop_now;

   // restoring divider, one quotient bit a step
   logic [TIME_W-1:0] dep_ff;
   logic [RATE_W-1:0] rate_ff, rem_ff;
   logic [PROD_W-1:0] quo_ff;
   logic [RATE_W:0]   trial;
   logic              ge;

   assign trial = {rem_ff, quo_ff[PROD_W-1]};
   assign ge    = trial >= {1'b0, rate_ff};

   // results
   logic              res_drop_ff, res_timed_ff, res_pen_ff;
   logic [TIME_W-1:0] res_dep_ff;

   assign nd_in = dep_ff + TIME_W'(quo_ff);
   assign wr_rec = '{window_count: wc_ff, window_start: ws_ff, penalty_end: pe_ff,
                     depart_time: res_drop_ff ? nd_ff : nd_in, penalty_flag: flag_ff};

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         wc_ff      <= wc;
         ws_ff      <= ws;
         pe_ff      <= pe;
         flag_ff    <= flag;
         nd_ff      <= rd_rec.depart_time;
         res_pen_ff <= (mode_ff == MODE_DYNAMIC) && flag;
      end
      if (cmd.check) begin
         res_drop_ff <= drop_now;
         dep_ff      <= dep;
         rate_ff     <= rate;
         rem_ff      <= '0;
         quo_ff      <= prod_ff;
      end
      if (cmd.div_step) begin
         rem_ff <= ge ? RATE_W'(trial - {1'b0, rate_ff}) : trial[RATE_W-1:0];
         quo_ff <= {quo_ff[PROD_W-2:0], ge};
      end
      if (cmd.write) begin
         res_timed_ff <= !res_drop_ff && !dir_ff;
         res_dep_ff   <= (!res_drop_ff && !dir_ff) ? nd_in : '0;
      end
      if (cmd.accept) begin
         res_drop_ff  <= 1'b0;
         res_timed_ff <= 1'b0;
         res_pen_ff   <= 1'b0;
         res_dep_ff   <= '0;
      end
      if (cmd.load_out) begin
         out_drop           <= res_drop_ff;
         out_timed          <= res_timed_ff;
         out_departure_time <= res_dep_ff;
         out_penalized      <= res_pen_ff;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/per_flow_departure_time_shaper.sv =====
// ----------------------------------------------------------------------------
// per_flow_departure_time_shaper
// earliest departure time pacer with per flow records and burst penalty
// ----------------------------------------------------------------------------
//  port group   dir   handshake          contents
//  req_if       in    valid/ready        direction, flow index, length, time
//  rsp_if       out   valid/ready        drop, timed, departure time, penalized
//  csr_*        in    write enable only  register index and data
//
//  after reset a clearing pass zeroes all 2*FLOWS records, one per cycle;
//  req_if.ready stays low until the clearing pass is done
//  a packet goes through read, evaluate, check, 46 divider steps, write and
//  output; a dropped packet skips the divider steps, and in mode 0 a packet
//  goes straight to output; the divider is a 46-step restoring divider
//  a finished transaction sits in the output register while the next
//  packet is taken and worked on
// ----------------------------------------------------------------------------
`default_nettype none
module per_flow_departure_time_shaper import pfdts_pkg::*; #(
   parameter int FLOWS = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   pfdts_req_if.sink                  req_if,
   pfdts_rsp_if.source                rsp_if,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);
   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic [$clog2(2*FLOWS)-1:0] clr_addr;

   // sequencer
   pfdts_ctrl #(.FLOWS(FLOWS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd),
      .clr_addr  (clr_addr)
   );

   // record memory, burst logic and divider
   pfdts_dp #(.FLOWS(FLOWS)) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .clr_addr           (clr_addr),
      .in_direction       (req_if.direction),
      .in_flow_index      (req_if.flow_index),
      .in_packet_length   (req_if.packet_length),
      .in_now             (req_if.now),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .out_drop           (rsp_if.drop),
      .out_timed          (rsp_if.timed),
      .out_departure_time (rsp_if.departure_time),
      .out_penalized      (rsp_if.penalized)
   );
endmodule
`default_nettype wire

// ===== rtl/pfdts_checker.sv =====
// ----------------------------------------------------------------------------
// pfdts_checker
// port level checks of the departure time shaper
// ----------------------------------------------------------------------------
`default_nettype none
module pfdts_checker import pfdts_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_drop,
   input wire logic              rsp_timed,
   input wire logic [TIME_W-1:0] rsp_departure_time
);
   logic [1:0] pend_ff, pend_in;
   logic       req_fire, rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign pend_in  = pend_ff + 2'(req_fire) - 2'(rsp_fire);

   always_ff @(posedge clock) begin
      if (reset) pend_ff <= '0;
      else       pend_ff <= pend_in;
   end

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("ready or valid during clearing pass");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result without pending transaction");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> pend_ff <= 2'd1)
      else $error("too many transactions in flight");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_departure_time)
                                  && $stable(rsp_drop) && $stable(rsp_timed))
      else $error("stalled result changed");
endmodule

bind per_flow_departure_time_shaper pfdts_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_drop           (rsp_if.drop),
   .rsp_timed          (rsp_if.timed),
   .rsp_departure_time (rsp_if.departure_time)
);
`default_nettype wire
